### sv/rcw_pkg.sv
package rcw_pkg;

  localparam int unsigned SEQ_W = 16;
  localparam int unsigned WIN_W = 16;
  localparam int unsigned DUP_W = 4;
  localparam int unsigned OUT_W = 72;

  localparam logic [SEQ_W-1:0] KEEPALIVE_ACK = '1;
  localparam logic [WIN_W-1:0] WIN_MAX = '1;
  localparam logic [WIN_W-1:0] CNT_MAX = '1;
  localparam logic [DUP_W-1:0] DUP_MAX = '1;

  localparam logic [WIN_W-1:0] RST_SSTHRESH = 16'd32;
  localparam logic [DUP_W-1:0] RST_DUP_LIMIT = 4'd3;

  localparam logic [0:0] CFG_SSTHRESH = 1'b0;
  localparam logic [0:0] CFG_DUP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    PH_SLOW_START = 2'd0,
    PH_AVOID = 2'd1,
    PH_RECOVERY = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_ACK = 2'd0,
    CMD_ROUND = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [3:0] pad;
    logic round_reached;
    logic [SEQ_W-1:0] retransmit_seq;
    logic retransmit;
    logic [SEQ_W-1:0] window_base;
    logic [1:0] phase;
    logic [WIN_W-1:0] slow_start_threshold;
    logic [WIN_W-1:0] window_size;
  } result_t;

endpackage

### sv/reno_congestion_window_control_unit.sv
// channel        dir  signals                         contents
// s_axis         in   tvalid/tready/tdata/tuser       ack event: tuser cmd, tdata ack_number
// m_axis         out  tvalid/tready/tdata             status of the window after each event
// cfg            in   we/idx/wdata                    initial ssthresh, duplicate ack limit
//
// one event per cycle unless m_axis stalls; each event is decoded and applied to the window
// state in its accept cycle, and its status lands in the output register on the same edge
// a status waiting in the output register does not block the next event when m_axis is ready
// reset (rst_ni low) puts the engine in slow start with window 1 and ssthresh 32
// a write of the ssthresh register also loads the live ssthresh
module reno_congestion_window_control_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // ack_number
  input  logic [1:0]  s_axis_tuser_i,   // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // window_size, slow_start_threshold, phase, window_base, retransmit, retransmit_seq,
  // round_reached, zero fill
  output logic [71:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  rcw_pkg::phase_e phase_q, phase_d;
  logic [15:0] hp1_q, hp1_d;
  logic [3:0]  dup_q, dup_d;
  logic [15:0] nac_q, nac_d;
  logic [15:0] ww_q, ww_d;
  logic [15:0] cw_q, cw_d;
  logic [15:0] ss_q, ss_d;
  logic [15:0] base_q, base_d;
  logic [16:0] exp_q, exp_d;
  logic        round_q, round_d;
  logic [3:0]  limit_q;
  logic        out_valid_q;
  rcw_pkg::result_t res_q, res_d;

  logic        accept;
  logic [15:0] ack;
  logic        is_new;
  logic        is_dup;
  logic        rtx;
  logic [3:0]  dup_inc;
  logic [15:0] nac_inc;
  logic [16:0] ww_sum;
  logic [15:0] ww_inc;
  logic [15:0] cw_dbl;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign ack = s_axis_tdata_i;
  assign is_new = (ack >= hp1_q);
  assign is_dup = (hp1_q != 16'd0) && (ack == (hp1_q - 16'd1));
  assign dup_inc = (dup_q == rcw_pkg::DUP_MAX) ? dup_q : dup_q + 4'd1;
  assign nac_inc = (nac_q == rcw_pkg::CNT_MAX) ? nac_q : nac_q + 16'd1;
  assign ww_sum = {1'b0, ww_q} + 17'd1;
  assign ww_inc = ww_sum[16] ? rcw_pkg::WIN_MAX : ww_sum[15:0];
  assign cw_dbl = cw_q[15] ? rcw_pkg::WIN_MAX : {cw_q[14:0], 1'b0};

  always_comb begin
    phase_d = phase_q;
    hp1_d = hp1_q;
    dup_d = dup_q;
    nac_d = nac_q;
    ww_d = ww_q;
    cw_d = cw_q;
    ss_d = ss_q;
    base_d = base_q;
    exp_d = exp_q;
    round_d = round_q;
    rtx = 1'b0;
    unique case (rcw_pkg::cmd_e'(s_axis_tuser_i))
      rcw_pkg::CMD_ACK: begin
        if (ack != rcw_pkg::KEEPALIVE_ACK) begin
          case (phase_q)
            rcw_pkg::PH_SLOW_START, rcw_pkg::PH_AVOID: begin
              if (is_new) begin
                hp1_d = ack + 16'd1;
                dup_d = '0;
                if (phase_q == rcw_pkg::PH_AVOID) begin
                  nac_d = nac_inc;
                  if (nac_inc == ww_q) begin
                    ww_d = ww_inc;
                  end
                end
              end else if (is_dup) begin
                dup_d = dup_inc;
                if (dup_inc == limit_q) begin
                  ss_d = {1'b0, ww_q[15:1]};
                  ww_d = {1'b0, ww_q[15:1]} + 16'd3;
                  phase_d = rcw_pkg::PH_RECOVERY;
                  rtx = 1'b1;
                end
              end
              if (phase_q == rcw_pkg::PH_SLOW_START && !rtx && ww_q >= ss_q) begin
                nac_d = '0;
                phase_d = rcw_pkg::PH_AVOID;
              end
            end
            rcw_pkg::PH_RECOVERY: begin
              if (is_new) begin
                hp1_d = ack + 16'd1;
                ww_d = (ss_q == 16'd0) ? 16'd1 : ss_q;
                dup_d = '0;
                nac_d = '0;
                phase_d = rcw_pkg::PH_AVOID;
              end else if (is_dup) begin
                ww_d = ww_inc;
              end
            end
            default: begin
            end
          endcase
          if ({1'b0, ack} >= exp_q) begin
            round_d = 1'b1;
          end
        end
      end
      rcw_pkg::CMD_ROUND: begin
        base_d = hp1_q;
        if (phase_q == rcw_pkg::PH_SLOW_START) begin
          cw_d = cw_dbl;
          ww_d = cw_dbl;
        end else begin
          cw_d = ww_q;
        end
        exp_d = {1'b0, base_d} + {1'b0, cw_d} - 17'd1;
        nac_d = '0;
        round_d = 1'b0;
      end
      rcw_pkg::CMD_TIMEOUT: begin
        base_d = hp1_q;
        ss_d = {1'b0, cw_q[15:1]};
        cw_d = 16'd1;
        ww_d = 16'd1;
        dup_d = '0;
        phase_d = rcw_pkg::PH_SLOW_START;
        exp_d = {1'b0, base_d} + {1'b0, cw_d} - 17'd1;
        nac_d = '0;
        round_d = 1'b0;
      end
      default: begin
      end
    endcase

    res_d.pad = '0;
    res_d.round_reached = round_d;
    res_d.retransmit_seq = rtx ? hp1_d : 16'd0;
    res_d.retransmit = rtx;
    res_d.window_base = base_d;
    res_d.phase = phase_d;
    res_d.slow_start_threshold = ss_d;
    res_d.window_size = cw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rcw_pkg::PH_SLOW_START;
      hp1_q <= '0;
      dup_q <= '0;
      nac_q <= '0;
      ww_q <= 16'd1;
      cw_q <= 16'd1;
      ss_q <= rcw_pkg::RST_SSTHRESH;
      base_q <= '0;
      exp_q <= '0;
      round_q <= 1'b0;
      limit_q <= rcw_pkg::RST_DUP_LIMIT;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        hp1_q <= hp1_d;
        dup_q <= dup_d;
        nac_q <= nac_d;
        ww_q <= ww_d;
        cw_q <= cw_d;
        base_q <= base_d;
        exp_q <= exp_d;
        round_q <= round_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_i == rcw_pkg::CFG_SSTHRESH)) begin
        ss_q <= cfg_wdata_i;
      end else if (accept) begin
        ss_q <= ss_d;
      end
      if (cfg_we_i && (cfg_idx_i == rcw_pkg::CFG_DUP_LIMIT)) begin
        limit_q <= cfg_wdata_i[3:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = res_q;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_ack = '0;
  logic [1:0]  s_cmd = '0;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  reno_congestion_window_control_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_ack),
    .s_axis_tuser_i  (s_cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // window engine state mirrored by the predictor
  logic [15:0]     cfg_ssth;
  logic [3:0]      cfg_dup_limit;
  rcw_pkg::phase_e cur_phase;
  int              top_ack;
  logic [3:0]      dups;
  logic [15:0]     new_acks;
  logic [15:0]     work_win;
  logic [15:0]     commit_win;
  logic [15:0]     ssth;
  int              base_seq;
  int              round_target;
  logic            round_hit;

  rcw_pkg::result_t status_q[$];
  int          mismatches = 0;
  int          status_cnt = 0;
  int          stall_left = 0;
  bit          no_gaps = 1'b0;
  int          ack_hi = -1;

  int          n_acks = 0;
  int          n_rounds = 0;
  int          n_timeouts = 0;
  int          n_rtx = 0;
  int          n_keepalive = 0;
  int          peak_win = 1;

  function automatic void reset_model();
    cfg_ssth = rcw_pkg::RST_SSTHRESH;
    cfg_dup_limit = rcw_pkg::RST_DUP_LIMIT;
    cur_phase = rcw_pkg::PH_SLOW_START;
    top_ack = -1;
    dups = '0;
    new_acks = '0;
    work_win = 16'd1;
    commit_win = 16'd1;
    ssth = rcw_pkg::RST_SSTHRESH;
    base_seq = 0;
    round_target = 0;
    round_hit = 1'b0;
  endfunction

  function automatic logic [15:0] sat16(int v);
    return (v > 65535) ? rcw_pkg::WIN_MAX : v[15:0];
  endfunction

  function automatic bit dup_hit();
    if (dups != rcw_pkg::DUP_MAX) dups++;
    if (dups == cfg_dup_limit) begin
      ssth = work_win >> 1;
      work_win = sat16(int'(ssth) + 3);
      cur_phase = rcw_pkg::PH_RECOVERY;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void open_round();
    round_target = base_seq + int'(commit_win) - 1;
    new_acks = '0;
    round_hit = 1'b0;
  endfunction

  function automatic rcw_pkg::result_t predict_status(logic [1:0] cmd, logic [15:0] ack);
    rcw_pkg::result_t r;
    bit rtx;
    bit is_new;
    bit is_dup;
    int a;
    rtx = 1'b0;
    r = '0;
    a = int'(ack);
    if (cmd == rcw_pkg::CMD_ACK && ack != rcw_pkg::KEEPALIVE_ACK) begin
      n_acks++;
      is_new = a > top_ack;
      is_dup = a == top_ack;
      case (cur_phase)
        rcw_pkg::PH_SLOW_START: begin
          if (is_new) begin
            top_ack = a;
            dups = '0;
          end else if (is_dup) begin
            rtx = dup_hit();
          end
          if (!rtx && work_win >= ssth) begin
            new_acks = '0;
            cur_phase = rcw_pkg::PH_AVOID;
          end
        end
        rcw_pkg::PH_AVOID: begin
          if (is_new) begin
            top_ack = a;
            if (new_acks != rcw_pkg::CNT_MAX) new_acks++;
            if (new_acks == work_win) work_win = sat16(int'(work_win) + 1);
            dups = '0;
          end else if (is_dup) begin
            rtx = dup_hit();
          end
        end
        default: begin
          if (is_new) begin
            top_ack = a;
            work_win = (ssth == 0) ? 16'd1 : ssth;
            dups = '0;
            new_acks = '0;
            cur_phase = rcw_pkg::PH_AVOID;
          end else if (is_dup) begin
            work_win = sat16(int'(work_win) + 1);
          end
        end
      endcase
      if (rtx) begin
        r.retransmit_seq = 16'(top_ack + 1);
        n_rtx++;
      end
      if (a >= round_target) round_hit = 1'b1;
    end else if (cmd == rcw_pkg::CMD_ACK) begin
      n_keepalive++;
    end else if (cmd == rcw_pkg::CMD_ROUND) begin
      n_rounds++;
      base_seq = top_ack + 1;
      if (cur_phase == rcw_pkg::PH_SLOW_START) begin
        commit_win = sat16(int'(commit_win) * 2);
        work_win = commit_win;
      end else begin
        commit_win = work_win;
      end
      open_round();
    end else if (cmd == rcw_pkg::CMD_TIMEOUT) begin
      n_timeouts++;
      base_seq = top_ack + 1;
      ssth = commit_win >> 1;
      commit_win = 16'd1;
      work_win = 16'd1;
      dups = '0;
      cur_phase = rcw_pkg::PH_SLOW_START;
      open_round();
    end
    if (int'(commit_win) > peak_win) peak_win = int'(commit_win);
    r.window_size = commit_win;
    r.slow_start_threshold = ssth;
    r.phase = cur_phase;
    r.window_base = base_seq[15:0];
    r.retransmit = rtx;
    r.round_reached = round_hit;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("status %0d %s: expected %0h, got %0h", status_cnt, name, want, got);
    end
  endtask

  // output side: compare statuses, then record new configuration and events
  always @(posedge clk_i) begin : status_mon
    rcw_pkg::result_t got;
    rcw_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        got = m_axis_tdata_o;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("status %0d arrived with none pending", status_cnt);
        end else begin
          want = status_q.pop_front();
          check_field("window_size", want.window_size, got.window_size);
          check_field("slow_start_threshold", want.slow_start_threshold,
                      got.slow_start_threshold);
          check_field("phase", 16'(want.phase), 16'(got.phase));
          check_field("window_base", want.window_base, got.window_base);
          check_field("retransmit", 16'(want.retransmit), 16'(got.retransmit));
          check_field("retransmit_seq", want.retransmit_seq, got.retransmit_seq);
          check_field("round_reached", 16'(want.round_reached), 16'(got.round_reached));
        end
        status_cnt++;
        stall_left = no_gaps ? 0 : $urandom_range(0, 17);
      end
      if (cfg_we) begin
        if (cfg_idx == rcw_pkg::CFG_SSTHRESH) begin
          cfg_ssth = cfg_wdata;
          ssth = cfg_wdata;
        end else begin
          cfg_dup_limit = cfg_wdata[3:0];
        end
      end
      if (s_valid && s_axis_tready_o) status_q.push_back(predict_status(s_cmd, s_ack));
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic send_event(logic [1:0] cmd, logic [15:0] ack);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_cmd <= cmd;
    s_ack <= ack;
    if (cmd == rcw_pkg::CMD_ACK && ack != rcw_pkg::KEEPALIVE_ACK && int'(ack) > ack_hi)
      ack_hi = int'(ack);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_events();
    send_event(rcw_pkg::CMD_ACK, 16'd0);
    repeat (3) send_event(rcw_pkg::CMD_ACK, 16'd0);    // third duplicate from slow start
    send_event(rcw_pkg::CMD_ACK, 16'd0);               // duplicate inflates recovery window
    send_event(rcw_pkg::CMD_ACK, rcw_pkg::KEEPALIVE_ACK);
    send_event(CMD_SPARE, 16'hAAAA);                   // unused command
    send_event(rcw_pkg::CMD_ACK, 16'd2);               // leave recovery with zero ssthresh
    send_event(rcw_pkg::CMD_ACK, 16'd3);
    send_event(rcw_pkg::CMD_ROUND, 16'h5555);
    send_event(rcw_pkg::CMD_ACK, 16'd1);               // stale ack
    send_event(rcw_pkg::CMD_ACK, 16'd5);
    send_event(rcw_pkg::CMD_TIMEOUT, 16'hFFFF);
    send_event(rcw_pkg::CMD_ACK, 16'd6);
    send_event(rcw_pkg::CMD_ROUND, 16'd0);
  endtask

  task automatic test_zero_dup_limit();
    settle();
    write_reg(rcw_pkg::CFG_DUP_LIMIT, 16'd0);
    write_reg(rcw_pkg::CFG_SSTHRESH, 16'd65535);
    repeat (5) send_event(rcw_pkg::CMD_ACK, 16'd6);    // duplicates never trigger
    send_event(rcw_pkg::CMD_TIMEOUT, 16'd0);
  endtask

  task automatic test_random_traffic(logic [15:0] ssth_val, logic [3:0] limit_val, int n);
    int sent;
    int kind;
    logic [15:0] a;
    settle();
    write_reg(rcw_pkg::CFG_SSTHRESH, ssth_val);
    write_reg(rcw_pkg::CFG_DUP_LIMIT, {12'd0, limit_val});
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        a = (ack_hi >= 60000) ? 16'(ack_hi) : 16'(ack_hi + $urandom_range(1, 3));
        send_event(rcw_pkg::CMD_ACK, a);
        sent++;
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 6)) begin
          send_event(rcw_pkg::CMD_ACK, (ack_hi < 0) ? 16'd0 : 16'(ack_hi));
          sent++;
        end
      end else if (kind < 78) begin
        send_event(rcw_pkg::CMD_ACK, 16'($urandom_range(0, (ack_hi < 0) ? 0 : ack_hi)));
        sent++;
      end else if (kind < 88) begin
        send_event(rcw_pkg::CMD_ROUND, 16'($urandom_range(0, 65535)));
        sent++;
      end else if (kind < 92) begin
        send_event(rcw_pkg::CMD_TIMEOUT, 16'($urandom_range(0, 65535)));
        sent++;
      end else if (kind < 95) begin
        send_event(rcw_pkg::CMD_ACK, rcw_pkg::KEEPALIVE_ACK);
        sent++;
      end else begin
        send_event(2'($urandom_range(1, 3)), 16'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  task automatic test_sequence_top();
    settle();
    write_reg(rcw_pkg::CFG_DUP_LIMIT, 16'd2);
    send_event(rcw_pkg::CMD_ACK, 16'd65534);
    repeat (2) send_event(rcw_pkg::CMD_ACK, 16'd65534);
    send_event(rcw_pkg::CMD_ROUND, 16'd0);
    send_event(rcw_pkg::CMD_ACK, rcw_pkg::KEEPALIVE_ACK);
    send_event(rcw_pkg::CMD_TIMEOUT, 16'd0);
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_events();
    test_zero_dup_limit();
    test_random_traffic(rcw_pkg::RST_SSTHRESH, rcw_pkg::RST_DUP_LIMIT, 255);
    test_random_traffic(16'd1, 4'd1, 255);
    test_random_traffic(16'd65535, 4'd15, 255);
    test_random_traffic(16'd65535, 4'd3, 255);
    test_random_traffic(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 15)), 255);
    test_random_traffic(16'($urandom_range(2, 200)), 4'd2, 255);
    test_sequence_top();
    settle();
    repeat (4) @(posedge clk_i);
    $display("events: %0d acks, %0d keepalives, %0d round ends, %0d timeouts, %0d statuses",
             n_acks, n_keepalive, n_rounds, n_timeouts, status_cnt);
    $display("fast retransmits: %0d, peak committed window: %0d", n_rtx, peak_win);
    if (mismatches == 0) begin
      $display("reno_congestion_window_control_unit test passed");
    end else begin
      $display("reno_congestion_window_control_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("reno_congestion_window_control_unit test failed");
    $finish;
  end

endmodule
